// ===== rtl/bma_pkg.sv =====
// shared types and constants of the buddy allocator
`default_nettype none
package bma_pkg;

    // block size limits, as logs of bytes
    localparam int MIN_BLOCK_LOG = 5;
    localparam int MAX_BLOCK_LOG = 20;

    // width of a stored block order
    localparam int ORD_W = 5;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 1'b1;

    // operation codes
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // result status codes
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // slot marks
    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_FREE = 2'd1,
        MARK_USED = 2'd2
    } t_mark;

    // input word
    typedef struct packed {
        logic        op;
        logic [31:0] request_size;
        logic [32:0] release_address;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        status;
        logic [32:0] granted_address;
        logic [20:0] used_bytes;
        logic [31:0] free_bytes;
    } t_out_word;

endpackage
`default_nettype wire

// ===== rtl/buddy_memory_allocator_unit.sv =====
// buddy allocator top level: sequencer, list heads and slot memories
//
// One word is taken at a time and its result comes out of an output register,
// so a new word may be accepted while the previous result waits. An allocate
// rounds the size to an order, scans the lists upwards from that order, pops a
// block and splits it down one order per split; a zero or oversized request is
// rejected at once, and so is a request when no block is free. A release checks
// the address and the slot's mark and order, then merges with the buddy while
// the buddy is free with the same order and a walk of its free list finds it;
// the buddy's mark or order, or a walk that misses, ends the merging, and the
// block is pushed onto its list. A rejected release stops at either check. The
// result stage holds while the previous result is not taken, and the sequencer
// returns to idle before the next word. The slot memories have one read port
// with a registered read, and that port sets the pace of the list walk. After
// reset a clearing pass over all 2^(MAX_BLOCK_LOG-MIN_BLOCK_LOG) slots sets the
// slot marks before the first word is accepted; configuration writes are taken always.
`default_nettype none
module buddy_memory_allocator_unit #(
    parameter int MIN_BLOCK_LOG = bma_pkg::MIN_BLOCK_LOG,
    parameter int MAX_BLOCK_LOG = bma_pkg::MAX_BLOCK_LOG
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  bma_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output bma_pkg::t_out_word              o_out_word,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [bma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [31:0]                      i_cfg_data
);

    localparam int SLOT_W  = MAX_BLOCK_LOG - MIN_BLOCK_LOG;
    localparam int LINK_W  = SLOT_W + 1;
    localparam int ORD_CNT = MAX_BLOCK_LOG - MIN_BLOCK_LOG + 1;
    localparam int LVL_W   = $clog2(ORD_CNT);
    localparam int USED_W  = MAX_BLOCK_LOG + 1;
    localparam int STEP_W  = SLOT_W + 2;
    localparam int ORD_W   = bma_pkg::ORD_W;
    localparam logic [LINK_W-1:0] NO_SLOT    = LINK_W'(1) << SLOT_W;
    localparam logic [STEP_W-1:0] SLOT_COUNT = STEP_W'(1) << SLOT_W;
    localparam logic [33:0]       GRAIN      = 34'(1) << MIN_BLOCK_LOG;
    localparam logic [ORD_W-1:0]  ORD_MIN    = ORD_W'(MIN_BLOCK_LOG);
    localparam logic [ORD_W-1:0]  ORD_MAX    = ORD_W'(MAX_BLOCK_LOG);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ASIZE, S_ASCAN, S_APOP, S_ASPLIT, S_AFIN,
        S_RCHECK, S_RREAD, S_RMERGE, S_RBUDDY, S_RWALK, S_RNEXT, S_RPUSH, S_FIN
    } t_state;

    // slot memories
    logic [LINK_W-1:0] mem_links  [2**SLOT_W];
    logic [ORD_W-1:0]  mem_orders [2**SLOT_W];
    logic [1:0]        mem_marks  [2**SLOT_W];

    // control registers
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [LINK_W-1:0]   r_heads [ORD_CNT];
    logic [LINK_W-1:0]   n_heads [ORD_CNT];
    logic [USED_W-1:0]   r_used, n_used;
    logic                r_out_valid, n_out_valid;
    bma_pkg::t_out_word  r_out_word, n_out_word;
    logic [33:0]         r_base_hdr;
    logic [31:0]         r_region;

    // working registers of one word
    logic [31:0]         r_size, n_size;
    logic [32:0]         r_addr, n_addr;
    logic [LVL_W-1:0]    r_want, n_want;
    logic [LVL_W:0]      r_lvl, n_lvl;
    logic [SLOT_W-1:0]   r_blk, n_blk;
    logic [SLOT_W-1:0]   r_bud, n_bud;
    logic [LINK_W-1:0]   r_prev, n_prev;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [ORD_W-1:0]    r_ord, n_ord;
    logic                r_ok, n_ok;
    logic [32:0]         r_grant, n_grant;

    // memory read data
    logic [LINK_W-1:0]   r_link_q;
    logic [ORD_W-1:0]    r_ord_q;
    logic [1:0]          r_mark_q;

    // memory access controls
    logic                link_we, link_re, mo_re, mark_we, ord_we;
    logic [SLOT_W-1:0]   link_waddr, link_raddr, mo_raddr, mark_waddr, ord_waddr;
    logic [LINK_W-1:0]   link_wdata;
    logic [1:0]          mark_wdata;
    logic [ORD_W-1:0]    ord_wdata;

    // helper values
    logic [33:0]         need, need_m1, rel_a, rel_off;
    logic [5:0]          size_ord;
    logic [LVL_W-1:0]    ord_lvl, lvl_dn;
    logic [SLOT_W-1:0]   bud_calc;
    logic [31:0]         region_rnd;
    logic [32:0]         cfg_base_ext;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign region_rnd = r_region & ~32'(GRAIN - 34'd1);
    assign ord_lvl    = LVL_W'(r_ord - ORD_MIN);
    assign lvl_dn     = LVL_W'(r_lvl - (LVL_W + 1)'(1));
    assign bud_calc   = r_blk ^ (SLOT_W'(1) << ord_lvl);
    assign rel_a      = {1'b0, r_addr} & ~(GRAIN - 34'd1);
    assign rel_off    = rel_a - r_base_hdr;
    assign cfg_base_ext = {1'b0, i_cfg_data};

    // rounded block order of an allocate size
    always_comb begin
        need    = ({2'b0, r_size} + (GRAIN + GRAIN - 34'd1)) & ~(GRAIN - 34'd1);
        need_m1 = need - 34'd1;
        size_ord = 6'(MIN_BLOCK_LOG);
        for (int b = 0; b < 34; b++) begin
            if (need_m1[b] && (b + 1 > MIN_BLOCK_LOG)) begin
                size_ord = 6'(b + 1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_hdr <= GRAIN;
            r_region   <= 32'd1048576;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bma_pkg::CFG_BASE_ADDRESS: r_base_hdr <=
                    ({1'b0, cfg_base_ext} + GRAIN - 34'd1 & ~(GRAIN - 34'd1)) + GRAIN;
                bma_pkg::CFG_REGION_SIZE:  r_region <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;  n_clr = r_clr;  n_heads = r_heads;  n_used = r_used;
        n_out_valid = r_out_valid;  n_out_word = r_out_word;
        n_size = r_size;  n_addr = r_addr;  n_want = r_want;
        n_lvl = r_lvl;  n_blk = r_blk;  n_bud = r_bud;  n_prev = r_prev;
        n_cur = r_cur;  n_steps = r_steps;  n_ord = r_ord;  n_ok = r_ok;
        n_grant = r_grant;
        link_we = 1'b0;  link_waddr = r_blk;  link_wdata = NO_SLOT;
        link_re = 1'b0;  link_raddr = r_blk;
        mo_re = 1'b0;    mo_raddr = r_blk;
        mark_we = 1'b0;  mark_waddr = r_blk;  mark_wdata = bma_pkg::MARK_FREE;
        ord_we = 1'b0;   ord_waddr = r_blk;   ord_wdata = r_ord;

        // result word leaves when taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // sweep the slot memories after reset
            S_CLEAR: begin
                mark_we = 1'b1;
                mark_waddr = r_clr;
                mark_wdata = (r_clr == '0) ? bma_pkg::MARK_FREE : bma_pkg::MARK_NONE;
                link_we = (r_clr == '0);
                link_waddr = r_clr;
                link_wdata = NO_SLOT;
                ord_we = (r_clr == '0);
                ord_waddr = r_clr;
                ord_wdata = ORD_MAX;
                n_clr = r_clr + SLOT_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_size  = i_in_word.request_size;
                    n_addr  = i_in_word.release_address;
                    n_ok    = 1'b0;
                    n_grant = '0;
                    n_state = (i_in_word.op == bma_pkg::OP_RELEASE) ? S_RCHECK : S_ASIZE;
                end
            end
            // allocate: size to order
            S_ASIZE: begin
                if (r_size == '0 || size_ord > 6'(MAX_BLOCK_LOG)) begin
                    n_state = S_FIN;
                end else begin
                    n_ord   = ORD_W'(size_ord);
                    n_want  = LVL_W'(size_ord - 6'(MIN_BLOCK_LOG));
                    n_lvl   = (LVL_W + 1)'(size_ord - 6'(MIN_BLOCK_LOG));
                    n_state = S_ASCAN;
                end
            end
            // find the smallest non-empty list
            S_ASCAN: begin
                if (r_lvl == (LVL_W + 1)'(ORD_CNT)) begin
                    n_state = S_FIN;
                end else if (r_heads[r_lvl[LVL_W-1:0]][SLOT_W]) begin
                    n_lvl = r_lvl + (LVL_W + 1)'(1);
                end else begin
                    n_blk = r_heads[r_lvl[LVL_W-1:0]][SLOT_W-1:0];
                    link_re = 1'b1;
                    link_raddr = r_heads[r_lvl[LVL_W-1:0]][SLOT_W-1:0];
                    n_state = S_APOP;
                end
            end
            S_APOP: begin
                n_heads[r_lvl[LVL_W-1:0]] = r_link_q;
                n_state = S_ASPLIT;
            end
            // push the upper half onto the list one order down
            S_ASPLIT: begin
                if (r_lvl == {1'b0, r_want}) begin
                    n_state = S_AFIN;
                end else begin
                    n_bud = r_blk + (SLOT_W'(1) << lvl_dn);
                    ord_we = 1'b1;  ord_waddr = n_bud;
                    ord_wdata = ORD_W'(lvl_dn) + ORD_MIN;
                    mark_we = 1'b1;  mark_waddr = n_bud;  mark_wdata = bma_pkg::MARK_FREE;
                    link_we = 1'b1;  link_waddr = n_bud;  link_wdata = r_heads[lvl_dn];
                    n_heads[lvl_dn] = {1'b0, n_bud};
                    n_lvl = {1'b0, lvl_dn};
                end
            end
            S_AFIN: begin
                mark_we = 1'b1;  mark_wdata = bma_pkg::MARK_USED;
                ord_we = 1'b1;   ord_wdata = r_ord;
                n_used  = r_used + (USED_W'(1) << r_ord);
                n_grant = 33'(r_base_hdr + (34'(r_blk) << MIN_BLOCK_LOG));
                n_ok    = 1'b1;
                n_state = S_FIN;
            end
            // release: address to slot
            S_RCHECK: begin
                if (r_addr == '0 || rel_a < r_base_hdr || (rel_off >> MAX_BLOCK_LOG) != '0) begin
                    n_state = S_FIN;
                end else begin
                    n_blk = rel_off[MAX_BLOCK_LOG-1:MIN_BLOCK_LOG];
                    mo_re = 1'b1;
                    mo_raddr = rel_off[MAX_BLOCK_LOG-1:MIN_BLOCK_LOG];
                    n_state = S_RREAD;
                end
            end
            S_RREAD: begin
                if (r_mark_q != bma_pkg::MARK_USED || r_ord_q < ORD_MIN || r_ord_q > ORD_MAX) begin
                    n_state = S_FIN;
                end else begin
                    mark_we = 1'b1;  mark_wdata = bma_pkg::MARK_FREE;
                    n_used = (r_used >= (USED_W'(1) << r_ord_q))
                           ? r_used - (USED_W'(1) << r_ord_q) : '0;
                    n_ord = r_ord_q;
                    n_state = S_RMERGE;
                end
            end
            // look at the buddy of the current block
            S_RMERGE: begin
                if (r_ord == ORD_MAX ||
                    (33'(bud_calc) << MIN_BLOCK_LOG) >= {1'b0, region_rnd}) begin
                    n_state = S_RPUSH;
                end else begin
                    n_bud = bud_calc;
                    mo_re = 1'b1;  mo_raddr = bud_calc;
                    n_state = S_RBUDDY;
                end
            end
            S_RBUDDY: begin
                if (r_mark_q != bma_pkg::MARK_FREE || r_ord_q != r_ord) begin
                    n_state = S_RPUSH;
                end else begin
                    n_prev  = NO_SLOT;
                    n_cur   = r_heads[ord_lvl];
                    n_steps = '0;
                    n_state = S_RWALK;
                end
            end
            // walk the free list in search of the buddy
            S_RWALK: begin
                if (r_cur[SLOT_W] || r_steps > SLOT_COUNT) begin
                    n_state = S_RPUSH;
                end else begin
                    link_re = 1'b1;  link_raddr = r_cur[SLOT_W-1:0];
                    n_state = S_RNEXT;
                end
            end
            S_RNEXT: begin
                if (r_cur[SLOT_W-1:0] == r_bud) begin
                    if (r_prev[SLOT_W]) begin
                        n_heads[ord_lvl] = r_link_q;
                    end else begin
                        link_we = 1'b1;
                        link_waddr = r_prev[SLOT_W-1:0];
                        link_wdata = r_link_q;
                    end
                    n_blk = (r_bud < r_blk) ? r_bud : r_blk;
                    n_ord = r_ord + ORD_W'(1);
                    ord_we = 1'b1;  ord_waddr = n_blk;  ord_wdata = n_ord;
                    n_state = S_RMERGE;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_link_q;
                    n_steps = r_steps + STEP_W'(1);
                    n_state = S_RWALK;
                end
            end
            S_RPUSH: begin
                link_we = 1'b1;  link_wdata = r_heads[ord_lvl];
                n_heads[ord_lvl] = {1'b0, r_blk};
                n_ok = 1'b1;
                n_state = S_FIN;
            end
            // hand the result to the output register
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word.status = r_ok ? bma_pkg::STATUS_DONE : bma_pkg::STATUS_REJECTED;
                    n_out_word.granted_address = r_ok ? r_grant : '0;
                    n_out_word.used_bytes = 21'(r_used);
                    n_out_word.free_bytes = (region_rnd > 32'(r_used))
                                          ? region_rnd - 32'(r_used) : '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ORD_CNT; i++) begin
                r_heads[i] <= (i == ORD_CNT - 1) ? '0 : NO_SLOT;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_heads     <= n_heads;
        end
        r_out_word <= n_out_word;
        r_size <= n_size;  r_addr <= n_addr;  r_want <= n_want;
        r_lvl <= n_lvl;    r_blk <= n_blk;    r_bud <= n_bud;  r_prev <= n_prev;
        r_cur <= n_cur;    r_steps <= n_steps;  r_ord <= n_ord;  r_ok <= n_ok;
        r_grant <= n_grant;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_links[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_q <= mem_links[link_raddr];
        end
    end

    // order and mark memories
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            mem_orders[ord_waddr] <= ord_wdata;
        end
        if (mark_we) begin
            mem_marks[mark_waddr] <= mark_wdata;
        end
        if (mo_re) begin
            r_ord_q  <= mem_orders[mo_raddr];
            r_mark_q <= mem_marks[mo_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bma_checker.sv =====
// port-level checks of the buddy allocator, bound to the top level
`default_nettype none
module bma_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_ready,
    input bma_pkg::t_in_word            i_in_word,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input bma_pkg::t_out_word           o_out_word,
    input wire                          i_cfg_valid,
    input wire                          o_cfg_ready,
    input wire [bma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire [31:0]                   i_cfg_data
);

    // a rejected word never carries an address
    a_reject_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == bma_pkg::STATUS_REJECTED)
        |-> (o_out_word.granted_address == '0))
        else $error("rejected word with a granted address");

    // one word at a time: ready drops once a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready held after a word was taken");

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

endmodule

bind buddy_memory_allocator_unit bma_checker u_bma_checker (.*);
`default_nettype wire
